// ===== rtl/core/smpp_pkg.sv =====
// Package for the signed message payload parser: parse phases, result
// kinds, verdict codes, byte tags and the state and result records.
// No dependencies.
`default_nettype none

package smpp_pkg;

  // Payload layout
  localparam logic [6:0]  MIN_PAYLOAD  = 7'd93;
  localparam logic [15:0] HASH_LAST    = 16'd15;   // last offset of the 16-byte hash
  localparam logic [15:0] SIG_LAST     = 16'd63;   // last offset of the 64-byte signature
  localparam logic [15:0] TS_LAST      = 16'd7;    // last offset of the 8-byte timestamp

  // MessagePack tags
  localparam logic [3:0]  FIXARRAY_HI  = 4'h9;
  localparam logic [3:0]  MIN_ENTRIES  = 4'd3;
  localparam logic [7:0]  TAG_FLOAT64  = 8'hCB;
  localparam logic [2:0]  FIXSTR_HI    = 3'b101;
  localparam logic [7:0]  TAG_STR8     = 8'hD9;
  localparam logic [7:0]  TAG_STR16    = 8'hDA;
  localparam logic [7:0]  TAG_BIN8     = 8'hC4;
  localparam logic [7:0]  TAG_BIN16    = 8'hC5;

  // Parse phases; order matters for the truncation verdict
  typedef enum logic [3:0] {
    PH_HASH     = 4'd0,
    PH_SIG      = 4'd1,
    PH_ARRAY    = 4'd2,
    PH_TSTAG    = 4'd3,
    PH_TS       = 4'd4,
    PH_T_TAG    = 4'd5,
    PH_T_LEN8   = 4'd6,
    PH_T_LENHI  = 4'd7,
    PH_T_LENLO  = 4'd8,
    PH_T_DATA   = 4'd9,
    PH_B_TAG    = 4'd10,
    PH_B_LEN8   = 4'd11,
    PH_B_LENHI  = 4'd12,
    PH_B_LENLO  = 4'd13,
    PH_B_DATA   = 4'd14,
    PH_IDLE     = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_HASH  = 3'd1,
    KIND_SIG   = 3'd2,
    KIND_TS    = 3'd3,
    KIND_TITLE = 3'd4,
    KIND_BODY  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_NOT_ARRAY   = 3'd2,
    ST_ARRAY_SHORT = 3'd3,
    ST_BAD_TS      = 3'd4,
    ST_BAD_TITLE   = 3'd5,
    ST_BAD_BODY    = 3'd6
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  byte_total;
    logic [15:0] field_offset;
    logic [15:0] remaining_length;
    logic [7:0]  length_high;
    logic [63:0] timestamp_shift;
    status_t     first_error;
  } parse_state_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [7:0]  value_byte;
    logic [15:0] offset;
    logic [63:0] timestamp_bits;
    logic        done_res;
    status_t     status;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_HASH,
    byte_total:       7'd0,
    field_offset:     16'd0,
    remaining_length: 16'd0,
    length_high:      8'd0,
    timestamp_shift:  64'd0,
    first_error:      ST_OK
  };

endpackage

`default_nettype wire

// ===== rtl/core/signed_message_payload_parser.sv =====
// Signed message payload parser, top level: input beat register, parse step,
// result register. Depends on smpp_pkg and smpp_step.
//
// Usage:
//   The slave channel takes one payload byte per beat, tlast on the final
//   byte. The master channel gives one beat per emitted field byte, per
//   completed timestamp, and one verdict beat on the final byte (tlast set,
//   status in tdata). Bytes that produce nothing give no master beat.
//   An accepted input beat passes the input register, then the result
//   register. Throughput is one byte per cycle while the receiver keeps
//   up; the single parse step between the two registers sets that figure.
//   When the receiver stalls, the result register holds and the input
//   register fills, then tready drops; no beat is lost or repeated.
//   Reset clears both registers' valid flags and returns the parser to the
//   start of a payload; the final byte of each payload does the same for
//   the parser state. Payloads follow each other with no gap.
//
`default_nettype none

module signed_message_payload_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // [7:0] value_byte, [23:8] offset,
                                           // [87:24] timestamp_bits, [90:88] status,
                                           // [95:91] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast    // done_res
);
  import smpp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_data;
  logic          in_last;
  logic          advance;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  logic          out_valid;
  parse_result_t out_res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  smpp_step u_step (
    .state      (state),
    .data_byte  (in_data),
    .last_byte  (in_last),
    .state_next (state_next),
    .result     (step_res)
  );

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.status, out_res.timestamp_bits,
                          out_res.offset, out_res.value_byte};
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.done_res;

endmodule

`default_nettype wire

// ===== rtl/core/smpp_step.sv =====
// One parse step: next parser state and result for one payload byte.
// Purely combinational. Depends on smpp_pkg.
`default_nettype none

module smpp_step (
  input  var smpp_pkg::parse_state_t  state,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  output smpp_pkg::parse_state_t      state_next,
  output smpp_pkg::parse_result_t     result
);
  import smpp_pkg::*;

  parse_state_t upd;
  logic         is_body;

  // Phase after a string header with the given length
  function automatic phase_t start_phase(input logic [15:0] len, input logic body);
    phase_t p;
    if (len == 16'd0) begin
      p = body ? PH_IDLE : PH_B_TAG;
    end else begin
      p = body ? PH_B_DATA : PH_T_DATA;
    end
    return p;
  endfunction

  assign is_body = (state.phase >= PH_B_TAG);

  // Next state
  always_comb begin
    upd = state;
    if (state.byte_total < MIN_PAYLOAD) begin
      upd.byte_total = state.byte_total + 7'd1;
    end
    case (state.phase)
      PH_HASH: begin
        upd.field_offset = state.field_offset + 16'd1;
        if (state.field_offset >= HASH_LAST) begin
          upd.field_offset = 16'd0;
          upd.phase        = PH_SIG;
        end
      end
      PH_SIG: begin
        upd.field_offset = state.field_offset + 16'd1;
        if (state.field_offset >= SIG_LAST) begin
          upd.field_offset = 16'd0;
          upd.phase        = PH_ARRAY;
        end
      end
      PH_ARRAY: begin
        if (data_byte[7:4] != FIXARRAY_HI) begin
          if (state.first_error == ST_OK) upd.first_error = ST_NOT_ARRAY;
          upd.phase = PH_IDLE;
        end else if (data_byte[3:0] < MIN_ENTRIES) begin
          if (state.first_error == ST_OK) upd.first_error = ST_ARRAY_SHORT;
          upd.phase = PH_IDLE;
        end else begin
          upd.phase = PH_TSTAG;
        end
      end
      PH_TSTAG: begin
        if (data_byte != TAG_FLOAT64) begin
          if (state.first_error == ST_OK) upd.first_error = ST_BAD_TS;
          upd.phase = PH_IDLE;
        end else begin
          upd.field_offset    = 16'd0;
          upd.timestamp_shift = 64'd0;
          upd.phase           = PH_TS;
        end
      end
      PH_TS: begin
        upd.timestamp_shift = {state.timestamp_shift[55:0], data_byte};
        upd.field_offset    = state.field_offset + 16'd1;
        if (state.field_offset >= TS_LAST) begin
          upd.field_offset = 16'd0;
          upd.phase        = PH_T_TAG;
        end
      end
      PH_T_TAG, PH_B_TAG: begin
        if (data_byte[7:5] == FIXSTR_HI) begin
          upd.field_offset     = 16'd0;
          upd.remaining_length = {11'd0, data_byte[4:0]};
          upd.phase            = start_phase({11'd0, data_byte[4:0]}, is_body);
        end else if (data_byte == TAG_STR8 || data_byte == TAG_BIN8) begin
          upd.phase = is_body ? PH_B_LEN8 : PH_T_LEN8;
        end else if (data_byte == TAG_STR16 || data_byte == TAG_BIN16) begin
          upd.phase = is_body ? PH_B_LENHI : PH_T_LENHI;
        end else begin
          if (state.first_error == ST_OK) begin
            upd.first_error = is_body ? ST_BAD_BODY : ST_BAD_TITLE;
          end
          upd.phase = PH_IDLE;
        end
      end
      PH_T_LEN8, PH_B_LEN8: begin
        upd.field_offset     = 16'd0;
        upd.remaining_length = {8'd0, data_byte};
        upd.phase            = start_phase({8'd0, data_byte}, is_body);
      end
      PH_T_LENHI, PH_B_LENHI: begin
        upd.length_high = data_byte;
        upd.phase       = is_body ? PH_B_LENLO : PH_T_LENLO;
      end
      PH_T_LENLO, PH_B_LENLO: begin
        upd.field_offset     = 16'd0;
        upd.remaining_length = {state.length_high, data_byte};
        upd.phase            = start_phase({state.length_high, data_byte}, is_body);
      end
      PH_T_DATA, PH_B_DATA: begin
        upd.field_offset     = state.field_offset + 16'd1;
        upd.remaining_length = state.remaining_length - 16'd1;
        if (state.remaining_length == 16'd1) begin
          upd.phase = is_body ? PH_IDLE : PH_B_TAG;
        end
      end
      default: begin
        // idle: drop bytes until the final one
      end
    endcase
    state_next = last_byte ? STATE_RESET : upd;
  end

  // Result
  always_comb begin
    result = '{
      emit: 1'b0, kind: KIND_NONE, value_byte: 8'd0, offset: 16'd0,
      timestamp_bits: 64'd0, done_res: 1'b0, status: ST_OK
    };
    case (state.phase)
      PH_HASH, PH_SIG: begin
        result.emit       = 1'b1;
        result.kind       = (state.phase == PH_HASH) ? KIND_HASH : KIND_SIG;
        result.value_byte = data_byte;
        result.offset     = state.field_offset;
      end
      PH_TS: begin
        if (state.field_offset >= TS_LAST) begin
          result.emit           = 1'b1;
          result.kind           = KIND_TS;
          result.timestamp_bits = upd.timestamp_shift;
        end
      end
      PH_T_DATA, PH_B_DATA: begin
        result.emit       = 1'b1;
        result.kind       = is_body ? KIND_BODY : KIND_TITLE;
        result.value_byte = data_byte;
        result.offset     = state.field_offset;
      end
      default: begin
      end
    endcase
    // Verdict on the final byte
    if (last_byte) begin
      result.emit     = 1'b1;
      result.done_res = 1'b1;
      if (upd.byte_total < MIN_PAYLOAD) begin
        result.status = ST_SHORT;
      end else if (upd.first_error != ST_OK) begin
        result.status = upd.first_error;
      end else if (upd.phase == PH_IDLE) begin
        result.status = ST_OK;
      end else if (upd.phase <= PH_ARRAY) begin
        result.status = ST_SHORT;
      end else if (upd.phase <= PH_TS) begin
        result.status = ST_BAD_TS;
      end else if (upd.phase < PH_B_TAG) begin
        result.status = ST_BAD_TITLE;
      end else begin
        result.status = ST_BAD_BODY;
      end
    end
  end

endmodule

`default_nettype wire
